### sv/hbond_pkg.sv
// Package for the hydrogen bond contact detector: command codes, widths and shared types.
// No dependencies.
package hbond_pkg;
  localparam int unsigned CoordW = 20;
  localparam int unsigned TagW   = 16;
  localparam int unsigned D2W    = 43;

  typedef enum logic [2:0] {
    CMD_REC_H    = 3'd0,
    CMD_REC_HVY  = 3'd1,
    CMD_LIG_H    = 3'd2,
    CMD_LIG_QRY  = 3'd3,
    CMD_CLEAR    = 3'd4
  } cmd_e;

  localparam logic REG_CUTOFF = 1'b0;
  localparam logic REG_BOND   = 1'b1;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;
endpackage

### sv/hbond_dist_unit.sv
// Shared squared-distance unit, two register stages: axis squares, then sum.
// Depends on hbond_pkg.
module hbond_dist_unit (
  input  logic                           clk_i,
  input  hbond_pkg::point_t              a_i,
  input  hbond_pkg::point_t              b_i,
  output logic [hbond_pkg::D2W-1:0]      d2_o
);
  logic signed [hbond_pkg::CoordW:0] dx, dy, dz;
  logic [2*hbond_pkg::CoordW+1:0] sx_q, sy_q, sz_q;

  always_comb begin
    dx = {a_i.x[hbond_pkg::CoordW-1], a_i.x} - {b_i.x[hbond_pkg::CoordW-1], b_i.x};
    dy = {a_i.y[hbond_pkg::CoordW-1], a_i.y} - {b_i.y[hbond_pkg::CoordW-1], b_i.y};
    dz = {a_i.z[hbond_pkg::CoordW-1], a_i.z} - {b_i.z[hbond_pkg::CoordW-1], b_i.z};
  end

  always_ff @(posedge clk_i) begin
    sx_q <= (2*hbond_pkg::CoordW+2)'(dx * dx);
    sy_q <= (2*hbond_pkg::CoordW+2)'(dy * dy);
    sz_q <= (2*hbond_pkg::CoordW+2)'(dz * dz);
    d2_o <= hbond_pkg::D2W'(sx_q) + hbond_pkg::D2W'(sy_q) + hbond_pkg::D2W'(sz_q);
  end
endmodule

### sv/hbond_contact_detector.sv
// Hydrogen bond contact detector: a sequencer walks the atom stores through one shared
// distance unit, one distance issued per cycle while a store is scanned.
// A hydrogen load only stores the atom and a clear empties the stores. A receptor O/N
// load scans the receptor hydrogens through the single distance unit, then stores the atom;
// a ligand query scans the ligand hydrogens, then the receptor O/N store in a donor and an
// acceptor pass, then flushes. Results come with a one-cycle strobe result_valid_o and cannot
// be stalled; all donates contacts come first, then accepts, last on the final.
module hbond_contact_detector #(
  parameter int unsigned HYDROGEN_DEPTH = 64,
  parameter int unsigned HEAVY_DEPTH    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command_i,
  input  logic signed [19:0] coord_x_i,
  input  logic signed [19:0] coord_y_i,
  input  logic signed [19:0] coord_z_i,
  input  logic        acceptor_capable_i,
  input  logic [15:0] atom_tag_i,
  input  logic [15:0] residue_number_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [11:0] cfg_data_i,
  output logic        result_valid_o,
  output logic        direction_o,
  output logic [15:0] ligand_tag_o,
  output logic [15:0] receptor_tag_o,
  output logic [15:0] receptor_residue_o,
  output logic [23:0] squared_distance_o,
  output logic        last_o
);
  localparam int unsigned HW = (HYDROGEN_DEPTH > 1) ? $clog2(HYDROGEN_DEPTH) : 1;
  localparam int unsigned RW = (HEAVY_DEPTH > 1) ? $clog2(HEAVY_DEPTH) : 1;
  localparam int unsigned HCW = $clog2(HYDROGEN_DEPTH + 1);
  localparam int unsigned RCW = $clog2(HEAVY_DEPTH + 1);
  localparam int unsigned W = hbond_pkg::D2W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_HSCAN = 6'b000010,
    S_HDONE = 6'b000100,
    S_RSCAN = 6'b001000,
    S_FLUSH = 6'b010000,
    S_STORE = 6'b100000
  } state_e;

  typedef struct packed {
    logic          v;
    logic          pass;
  } tok_t;

  state_e state_q, state_d;
  logic [11:0] cutoff_q;
  logic [9:0]  bond_q;
  logic [HCW-1:0] rh_cnt_q, lh_cnt_q;
  logic [RCW-1:0] rv_cnt_q;

  hbond_pkg::point_t rh_mem [HYDROGEN_DEPTH];
  hbond_pkg::point_t lh_mem [HYDROGEN_DEPTH];
  hbond_pkg::point_t rv_mem [HEAVY_DEPTH];
  logic [33:0]       ri_mem [HEAVY_DEPTH];

  hbond_pkg::point_t p_q;
  logic [2:0]  cmd_q;
  logic        acc_q;
  logic [15:0] tag_q, res_q;
  logic        donor_q, pass_q;
  logic [HCW-1:0] ptr_q;
  logic [RW:0]    rptr_q;

  hbond_pkg::point_t hrd_q, rrd_q;
  logic [33:0] ri_rd_q;
  logic        hsel_q;
  tok_t t0_q, t1_q, t2_q;
  logic [33:0] i1_q, i2_q;
  logic [W-1:0] d2;
  logic [23:0] lim_c_q;
  logic [19:0] lim_b_q;
  logic pend_q;
  logic [15:0] prt_q, prr_q;
  logic [23:0] pd_q;
  logic pdir_q;

  assign busy        = !(state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= 12'd896;
      bond_q   <= 10'd320;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == hbond_pkg::REG_CUTOFF) cutoff_q <= cfg_data_i;
      else bond_q <= cfg_data_i[9:0];
    end
  end

  always_ff @(posedge clk_i) begin
    lim_c_q <= cutoff_q * cutoff_q;
    lim_b_q <= bond_q * bond_q;
  end

  // Memory reads, registered.
  always_ff @(posedge clk_i) begin
    hrd_q   <= (cmd_q == hbond_pkg::CMD_LIG_QRY) ? lh_mem[ptr_q[HW-1:0]]
                                                  : rh_mem[ptr_q[HW-1:0]];
    rrd_q   <= rv_mem[rptr_q[RW-1:0]];
    ri_rd_q <= ri_mem[rptr_q[RW-1:0]];
  end

  hbond_dist_unit u_dist (
    .clk_i (clk_i),
    .a_i   (p_q),
    .b_i   (hsel_q ? hrd_q : rrd_q),
    .d2_o  (d2)
  );

  logic issue_h, issue_r;
  logic [HCW-1:0] hcnt;
  assign hcnt    = (cmd_q == hbond_pkg::CMD_LIG_QRY) ? lh_cnt_q : rh_cnt_q;
  assign issue_h = (state_q == S_HSCAN) && (ptr_q < hcnt);
  assign issue_r = (state_q == S_RSCAN) && (RCW'(rptr_q) < rv_cnt_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start) state_d = S_STORE;
      S_STORE: begin
        if (cmd_q == hbond_pkg::CMD_REC_HVY || cmd_q == hbond_pkg::CMD_LIG_QRY)
          state_d = S_HSCAN;
        else state_d = S_IDLE;
      end
      S_HSCAN: if (!(ptr_q < hcnt)) state_d = S_HDONE;
      S_HDONE: if (!t0_q.v && !t1_q.v && !t2_q.v) begin
        if (cmd_q == hbond_pkg::CMD_LIG_QRY) state_d = S_RSCAN;
        else state_d = S_IDLE;
      end
      S_RSCAN: if (!(RCW'(rptr_q) < rv_cnt_q) && pass_q) state_d = S_FLUSH;
      S_FLUSH: if (!t0_q.v && !t1_q.v && !t2_q.v) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  logic hit, dout, rok;
  always_comb begin
    hit  = t2_q.v && (d2 <= W'(lim_c_q));
    rok  = t2_q.pass ? i2_q[1] : i2_q[0];
    dout = hit && rok && (t2_q.pass ? acc_q : donor_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rh_cnt_q <= '0;
      lh_cnt_q <= '0;
      rv_cnt_q <= '0;
      t0_q <= '0; t1_q <= '0; t2_q <= '0;
      pend_q <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      result_valid_o <= 1'b0;
      t0_q <= '0;
      t1_q <= t0_q;
      t2_q <= t1_q;
      if (state_q == S_STORE) begin
        case (cmd_q)
          hbond_pkg::CMD_REC_H: if (rh_cnt_q < HCW'(HYDROGEN_DEPTH)) rh_cnt_q <= rh_cnt_q + 1'b1;
          hbond_pkg::CMD_LIG_H: if (lh_cnt_q < HCW'(HYDROGEN_DEPTH)) lh_cnt_q <= lh_cnt_q + 1'b1;
          hbond_pkg::CMD_CLEAR: begin
            rh_cnt_q <= '0; lh_cnt_q <= '0; rv_cnt_q <= '0;
          end
          default: ;
        endcase
      end
      if (issue_h || issue_r) t0_q.v <= 1'b1;
      t0_q.pass <= pass_q;
      if (state_q == S_HDONE && state_d != S_HDONE && cmd_q == hbond_pkg::CMD_REC_HVY
          && rv_cnt_q < RCW'(HEAVY_DEPTH))
        rv_cnt_q <= rv_cnt_q + 1'b1;
      // Delay one contact so the final one can be flagged.
      if (state_q == S_RSCAN || state_q == S_FLUSH) begin
        if (dout) begin
          if (pend_q) result_valid_o <= 1'b1;
          pend_q <= 1'b1;
        end else if (state_q == S_FLUSH && !t0_q.v && !t1_q.v && !t2_q.v && pend_q) begin
          result_valid_o <= 1'b1;
          pend_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      p_q.x <= coord_x_i; p_q.y <= coord_y_i; p_q.z <= coord_z_i;
      cmd_q <= command_i;
      acc_q <= acceptor_capable_i;
      tag_q <= atom_tag_i;
      res_q <= residue_number_i;
    end
    i1_q <= ri_rd_q;
    i2_q <= i1_q;
    hsel_q <= (state_q == S_HSCAN);
    last_o <= 1'b0;
    if (state_q == S_STORE) begin
      ptr_q   <= '0;
      rptr_q  <= '0;
      pass_q  <= 1'b0;
      donor_q <= 1'b0;
      case (cmd_q)
        hbond_pkg::CMD_REC_H:
          if (rh_cnt_q < HCW'(HYDROGEN_DEPTH)) rh_mem[rh_cnt_q[HW-1:0]] <= p_q;
        hbond_pkg::CMD_LIG_H:
          if (lh_cnt_q < HCW'(HYDROGEN_DEPTH)) lh_mem[lh_cnt_q[HW-1:0]] <= p_q;
        default: ;
      endcase
    end
    if (issue_h) ptr_q <= ptr_q + 1'b1;
    if (state_q == S_HSCAN || state_q == S_HDONE) begin
      if (t2_q.v && d2 <= W'(lim_b_q)) donor_q <= 1'b1;
    end
    if (state_q == S_HDONE && state_d != S_HDONE && cmd_q == hbond_pkg::CMD_REC_HVY
        && rv_cnt_q < RCW'(HEAVY_DEPTH)) begin
      rv_mem[rv_cnt_q[RW-1:0]] <= p_q;
      ri_mem[rv_cnt_q[RW-1:0]] <= {tag_q, res_q, donor_q, acc_q};
    end
    if (state_q == S_RSCAN) begin
      if (issue_r) rptr_q <= rptr_q + 1'b1;
      else if (!pass_q) begin
        pass_q <= 1'b1;
        rptr_q <= '0;
      end
    end
    if ((state_q == S_RSCAN || state_q == S_FLUSH) && dout) begin
      pdir_q <= t2_q.pass;
      prt_q  <= i2_q[33:18];
      prr_q  <= i2_q[17:2];
      pd_q   <= d2[23:0];
    end
    if (((state_q == S_RSCAN || state_q == S_FLUSH) && dout && pend_q) ||
        (state_q == S_FLUSH && !dout && !t0_q.v && !t1_q.v && !t2_q.v && pend_q)) begin
      direction_o        <= pdir_q;
      ligand_tag_o       <= tag_q;
      receptor_tag_o     <= prt_q;
      receptor_residue_o <= prr_q;
      squared_distance_o <= pd_q;
      last_o             <= !dout;
    end
  end
endmodule

### bench/tb.sv
// Testbench for hbond_contact_detector: directed table, store overflow, then random load/query sequences.
// Depends on hbond_pkg and the detector RTL; results are checked against an in-bench predictor.
module tb;
  localparam int HDEPTH = 64;
  localparam int RDEPTH = 32;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [2:0]         cmd;
    logic signed [19:0] x, y, z;
    logic               acc;
    logic [15:0]        tag, res;
  } atom_cmd_t;

  typedef struct {
    logic        dir;
    logic [15:0] lig_tag, rec_tag, rec_res;
    logic [23:0] d2;
    logic        last;
  } contact_t;

  typedef struct {
    logic [2:0] cmd;
    int         x, y, z;
    logic       acc;
    logic [15:0] tag, res;
    logic       has_exp;
    logic [23:0] exp_d2;
  } row_t;

  logic clk_i = 0, rst_ni = 0;
  logic start = 0;
  logic busy;
  logic [2:0] command_i = 0;
  logic signed [19:0] coord_x_i = 0, coord_y_i = 0, coord_z_i = 0;
  logic acceptor_capable_i = 0;
  logic [15:0] atom_tag_i = 0, residue_number_i = 0;
  logic cfg_valid_i = 0, cfg_index_i = 0;
  logic cfg_ready_o;
  logic [11:0] cfg_data_i = 0;
  logic result_valid_o, direction_o, last_o;
  logic [15:0] ligand_tag_o, receptor_tag_o, receptor_residue_o;
  logic [23:0] squared_distance_o;

  hbond_contact_detector DUT (.*);

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  // Predictor state.
  logic [11:0] cutoff_q = 12'd896;
  logic [9:0]  bond_q = 10'd320;
  hbond_pkg::point_t rec_h[HDEPTH];
  hbond_pkg::point_t lig_h[HDEPTH];
  hbond_pkg::point_t rec_p[RDEPTH];
  logic [15:0] rec_tag[RDEPTH], rec_res[RDEPTH];
  logic rec_don[RDEPTH], rec_acc[RDEPTH];
  int n_rec_h = 0, n_lig_h = 0, n_rec = 0;

  contact_t expected_contacts[$];
  int errors = 0, mismatches = 0, results_seen = 0, items_sent = 0, idle_cycles = 0;

  function automatic longint unsigned sq_dist(hbond_pkg::point_t a, hbond_pkg::point_t b);
    longint dx, dy, dz;
    dx = longint'(a.x) - longint'(b.x);
    dy = longint'(a.y) - longint'(b.y);
    dz = longint'(a.z) - longint'(b.z);
    return dx*dx + dy*dy + dz*dz;
  endfunction

  function automatic logic bonded(hbond_pkg::point_t p, ref hbond_pkg::point_t st[HDEPTH],
                                  input int n);
    longint unsigned lim;
    lim = longint'(bond_q) * longint'(bond_q);
    for (int i = 0; i < n; i++) if (sq_dist(p, st[i]) <= lim) return 1;
    return 0;
  endfunction

  task automatic predict_contacts(atom_cmd_t a);
    hbond_pkg::point_t p;
    logic don, ok;
    longint unsigned lim, d2;
    contact_t c;
    int first;
    p.x = a.x; p.y = a.y; p.z = a.z;
    case (a.cmd)
      hbond_pkg::CMD_REC_H: if (n_rec_h < HDEPTH) begin rec_h[n_rec_h] = p; n_rec_h++; end
      hbond_pkg::CMD_LIG_H: if (n_lig_h < HDEPTH) begin lig_h[n_lig_h] = p; n_lig_h++; end
      hbond_pkg::CMD_REC_HVY: if (n_rec < RDEPTH) begin
        rec_tag[n_rec] = a.tag; rec_res[n_rec] = a.res; rec_acc[n_rec] = a.acc;
        rec_don[n_rec] = bonded(p, rec_h, n_rec_h); rec_p[n_rec] = p; n_rec++;
      end
      hbond_pkg::CMD_CLEAR: begin n_rec_h = 0; n_lig_h = 0; n_rec = 0; end
      hbond_pkg::CMD_LIG_QRY: begin
        first = expected_contacts.size();
        don = bonded(p, lig_h, n_lig_h);
        lim = longint'(cutoff_q) * longint'(cutoff_q);
        for (int pass = 0; pass < 2; pass++) begin
          if (pass == 0 ? !don : !a.acc) continue;
          for (int i = 0; i < n_rec; i++) begin
            ok = pass == 0 ? rec_acc[i] : rec_don[i];
            if (!ok) continue;
            d2 = sq_dist(p, rec_p[i]);
            if (d2 > lim) continue;
            c.dir = pass[0]; c.lig_tag = a.tag; c.rec_tag = rec_tag[i];
            c.rec_res = rec_res[i]; c.d2 = d2[23:0]; c.last = 0;
            expected_contacts.push_back(c);
          end
        end
        if (expected_contacts.size() > first)
          expected_contacts[expected_contacts.size()-1].last = 1;
      end
      default: ;
    endcase
  endtask

  // Result checker; results cannot be stalled, so sample on every edge.
  always @(posedge clk_i) begin
    contact_t e;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (expected_contacts.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("unexpected contact tag %0h", ligand_tag_o);
        mismatches++;
      end else begin
        e = expected_contacts.pop_front();
        if (e.dir !== direction_o || e.lig_tag !== ligand_tag_o ||
            e.rec_tag !== receptor_tag_o || e.rec_res !== receptor_residue_o ||
            e.d2 !== squared_distance_o || e.last !== last_o) begin
          errors++;
          if (mismatches < 10) begin
            $display("mismatch exp dir%0d lt%h rt%h rr%h d2 %0d last%0d",
                     e.dir, e.lig_tag, e.rec_tag, e.rec_res, e.d2, e.last);
            $display("         got dir%0d lt%h rt%h rr%h d2 %0d last%0d", direction_o,
                     ligand_tag_o, receptor_tag_o, receptor_residue_o,
                     squared_distance_o, last_o);
          end
          mismatches++;
        end
      end
    end
  end

  // Watchdog: cycles without any accepted transaction.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("Some tests failed");
      $finish;
    end
  end

  // Start stays high after an accepted transaction; a drain or the next call's gap lowers it.
  task automatic send_atom(atom_cmd_t a);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1; command_i <= a.cmd; coord_x_i <= a.x; coord_y_i <= a.y; coord_z_i <= a.z;
    acceptor_capable_i <= a.acc; atom_tag_i <= a.tag; residue_number_i <= a.res;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_contacts(a);
    items_sent++;
  endtask

  task automatic drain_results();
    start <= 0;
    while (expected_contacts.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [11:0] val);
    drain_results();
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 0;
    if (idx == hbond_pkg::REG_CUTOFF) cutoff_q = val; else bond_q = val[9:0];
  endtask

  function automatic atom_cmd_t make_atom(logic [2:0] cmd, int x, int y, int z, logic acc,
                                          logic [15:0] tag, logic [15:0] res);
    atom_cmd_t a;
    a.cmd = cmd; a.x = 20'(x); a.y = 20'(y); a.z = 20'(z);
    a.acc = acc; a.tag = tag; a.res = res;
    return a;
  endfunction

  function automatic int near_coord(int base, int spread);
    int v;
    v = base + $urandom_range(0, 2*spread) - spread;
    if (v > 524287) v = 524287;
    if (v < -524288) v = -524288;
    return v;
  endfunction

  // Random cluster: clear, receptor H, receptor O/N, ligand H, then several queries.
  task automatic random_scene();
    int cx, cy, cz, nh, nr, nl, nq, sp;
    cx = $urandom_range(0, 1048575) - 524288;
    cy = $urandom_range(0, 1048575) - 524288;
    cz = $urandom_range(0, 1048575) - 524288;
    sp = $urandom_range(0, 3) == 0 ? 4000 : 700;
    send_atom(make_atom(hbond_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0));
    nh = $urandom_range(0, 8); nr = $urandom_range(1, 8);
    nl = $urandom_range(0, 4); nq = $urandom_range(1, 5);
    for (int i = 0; i < nh; i++)
      send_atom(make_atom(hbond_pkg::CMD_REC_H, near_coord(cx, sp), near_coord(cy, sp),
                          near_coord(cz, sp), 1'($urandom), 16'($urandom), 16'($urandom)));
    for (int i = 0; i < nr; i++)
      send_atom(make_atom(hbond_pkg::CMD_REC_HVY, near_coord(cx, sp), near_coord(cy, sp),
                          near_coord(cz, sp), 1'($urandom), 16'($urandom), 16'($urandom)));
    for (int i = 0; i < nl; i++)
      send_atom(make_atom(hbond_pkg::CMD_LIG_H, near_coord(cx, sp), near_coord(cy, sp),
                          near_coord(cz, sp), 1'($urandom), 16'($urandom), 16'($urandom)));
    for (int i = 0; i < nq; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_atom(make_atom(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom,
                            1'($urandom), 16'($urandom), 16'($urandom)));
      send_atom(make_atom(hbond_pkg::CMD_LIG_QRY, near_coord(cx, sp), near_coord(cy, sp),
                          near_coord(cz, sp), 1'($urandom), 16'($urandom), 16'($urandom)));
    end
  endtask

  row_t directed[$];

  initial begin
    atom_cmd_t a;
    int scenes;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Query on empty stores, then a full donor/acceptor pair at range, unused commands, extremes.
    directed = '{
      '{hbond_pkg::CMD_LIG_QRY, 0, 0, 0, 1, 16'h1111, 16'h0, 0, 0},
      '{hbond_pkg::CMD_REC_H, 256, 0, 0, 0, 16'hFFFF, 16'hFFFF, 0, 0},
      '{hbond_pkg::CMD_REC_HVY, 0, 0, 0, 1, 16'hAAAA, 16'h5555, 0, 0},
      '{hbond_pkg::CMD_REC_HVY, 896, 0, 0, 0, 16'h0001, 16'hFFFF, 0, 0},
      '{hbond_pkg::CMD_LIG_H, 0, 100, 0, 0, 0, 0, 0, 0},
      '{hbond_pkg::CMD_LIG_QRY, 0, 0, 0, 1, 16'hFFFF, 16'hFFFF, 1, 24'd0},
      '{hbond_pkg::CMD_LIG_QRY, 0, 897, 0, 0, 16'h2222, 0, 0, 0},
      '{3'd7, 0, 0, 0, 1, 16'h7777, 16'h7777, 0, 0},
      '{3'd5, 0, 0, 0, 1, 0, 0, 0, 0},
      '{hbond_pkg::CMD_CLEAR, 524287, -524288, 0, 1, 16'hFFFF, 16'hFFFF, 0, 0},
      '{hbond_pkg::CMD_REC_HVY, 524287, 524287, 524287, 1, 16'h0F0F, 16'hF0F0, 0, 0},
      '{hbond_pkg::CMD_LIG_QRY, -524288, -524288, -524288, 1, 16'h3333, 0, 0, 0},
      '{hbond_pkg::CMD_LIG_QRY, 524287, 524287, 524287, 0, 16'h4444, 0, 0, 0},
      '{hbond_pkg::CMD_LIG_H, 524287, 524287, 524287, 0, 0, 0, 0, 0},
      '{hbond_pkg::CMD_LIG_QRY, 524287, 524287, 524287, 0, 16'h5555, 16'h1, 1, 24'd0},
      '{hbond_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0}
    };
    foreach (directed[i]) begin
      a = make_atom(directed[i].cmd, directed[i].x, directed[i].y, directed[i].z,
                    directed[i].acc, directed[i].tag, directed[i].res);
      send_atom(a);
      // Rows with a typed-in value must end in a contact at that distance.
      if (directed[i].has_exp && (expected_contacts.size() == 0 ||
          expected_contacts[expected_contacts.size()-1].d2 !== directed[i].exp_d2)) begin
        errors++;
        $display("directed row %0d predicts no contact at distance %0d", i,
                 directed[i].exp_d2);
      end
    end
    drain_results();

    // Store overflow: more than the depths.
    for (int i = 0; i < HDEPTH + 3; i++)
      send_atom(make_atom(hbond_pkg::CMD_REC_H, i*4, 0, 0, 0, 0, 0));
    for (int i = 0; i < RDEPTH + 2; i++)
      send_atom(make_atom(hbond_pkg::CMD_REC_HVY, i*8, 0, 0, 1, 16'(i), 16'(i+100)));
    send_atom(make_atom(hbond_pkg::CMD_LIG_QRY, 60, 0, 0, 1, 16'hBEEF, 0));
    drain_results();

    scenes = 0;
    while (items_sent < 330 || scenes < 8) begin
      case (scenes % 6)
        0: begin write_reg(hbond_pkg::REG_CUTOFF, 12'($urandom_range(0, 4095)));
                 write_reg(hbond_pkg::REG_BOND, 12'($urandom_range(0, 1023))); end
        1: begin write_reg(hbond_pkg::REG_CUTOFF, 12'd4095);
                 write_reg(hbond_pkg::REG_BOND, 12'd1023); end
        2: begin write_reg(hbond_pkg::REG_CUTOFF, 12'd0);
                 write_reg(hbond_pkg::REG_BOND, 12'd0); end
        3: begin write_reg(hbond_pkg::REG_CUTOFF, 12'd896);
                 write_reg(hbond_pkg::REG_BOND, 12'd320); end
        default: ;
      endcase
      random_scene();
      if (scenes % 5 == 4) drain_results();
      scenes++;
    end

    drain_results();
    $display("Sent %0d commands in %0d random scenes, checked %0d contacts.",
             items_sent, scenes, results_seen);
    if (errors == 0 && expected_contacts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d contacts missing", errors, expected_contacts.size());
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
